>>> design/c3zp_pkg.sv
// ----------------------------------------------------------------------------
// c3zp_pkg
// Shared widths, register indexes, reset values, item flags and the kernel
// coefficient helper of the streaming 3x3 convolution.
// ----------------------------------------------------------------------------
package c3zp_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int KERNEL_SIZE       = 3;

   localparam int PIX_W       = 16;
   localparam int COEF_W      = 16;
   localparam int SUM_W       = 32;
   localparam int WIDTH_REG_W = 11;
   localparam int ROW_W       = 16;
   localparam int KROW_W      = 48;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_TOP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MIDDLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_BOTTOM = 3'd4;

   localparam int                IMAGE_WIDTH_RESET  = 1024;
   localparam logic [ROW_W-1:0]  IMAGE_HEIGHT_RESET = 16'd1024;
   localparam logic [KROW_W-1:0] KERNEL_TOP_RESET    = 48'd0;
   localparam logic [KROW_W-1:0] KERNEL_MIDDLE_RESET = 48'd4096;
   localparam logic [KROW_W-1:0] KERNEL_BOTTOM_RESET = 48'd0;

   typedef struct packed {
      logic has_out;
      logic commit_wr;
      logic left_en;
      logic right_en;
      logic use_top;
      logic use_mid;
      logic use_bot;
      logic row_end;
      logic frame_end;
   } item_flags_type;

   function automatic logic signed [COEF_W-1:0] coef(input logic [KROW_W-1:0] row,
                                                      input int unsigned      col);
      return $signed(row[COEF_W*col +: COEF_W]);
   endfunction

endpackage

>>> design/c3zp_ctrl.sv
// ----------------------------------------------------------------------------
// c3zp_ctrl
// Configuration registers and the raster position counters. Decides for each
// transfer whether it is dropped, produces a result, and which neighbors are
// inside the image.
// ----------------------------------------------------------------------------
module c3zp_ctrl #(
   parameter int MAX_WIDTH = c3zp_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           csr_we,
   input  logic [c3zp_pkg::CSR_IDX_W-1:0]                 csr_index,
   input  logic [c3zp_pkg::CSR_DATA_W-1:0]                csr_wdata,
   input  logic                                           accept,
   input  logic                                           mode,
   output c3zp_pkg::item_flags_type                       flags,
   output logic                                           ignore,
   output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] addr,
   output logic [c3zp_pkg::KERNEL_SIZE-1:0][c3zp_pkg::KROW_W-1:0] kernel
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = c3zp_pkg::ROW_W + 1;
   localparam logic [WW-1:0] RESET_W = WW'((c3zp_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                                           MAX_WIDTH : c3zp_pkg::IMAGE_WIDTH_RESET);

   logic [WW-1:0]                 width_ff,   width_in;
   logic [c3zp_pkg::ROW_W-1:0]    height_ff,  height_in;
   logic [c3zp_pkg::KERNEL_SIZE-1:0][c3zp_pkg::KROW_W-1:0] kern_ff, kern_in;
   logic [AW-1:0]                 in_col_ff,  in_col_in;
   logic [RW-1:0]                 in_row_ff,  in_row_in;
   logic [AW-1:0]                 out_col_ff, out_col_in;
   logic [c3zp_pkg::ROW_W-1:0]    out_row_ff, out_row_in;

   logic [c3zp_pkg::WIDTH_REG_W-1:0] wr_width;
   logic [WW-1:0]                 eff_width;
   logic [RW-1:0]                 height_ext;
   logic                          restart;
   logic                          in_image;
   logic                          produce;
   logic                          in_col_last;
   logic                          rend;
   logic                          fend;

   assign wr_width = csr_wdata[c3zp_pkg::WIDTH_REG_W-1:0];

   always_comb begin
      if (wr_width == '0) begin
         eff_width = WW'(1);
      end else if (32'(wr_width) > MAX_WIDTH) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(wr_width);
      end
   end

   assign height_ext  = {1'b0, height_ff};
   assign in_image    = in_row_ff < height_ext;
   assign ignore      = mode && in_image;
   assign produce     = (in_row_ff > RW'(1)) || ((in_row_ff == RW'(1)) && (in_col_ff != '0));
   assign in_col_last = (WW'(in_col_ff) + WW'(1)) >= width_ff;
   assign rend        = (WW'(out_col_ff) + WW'(1)) >= width_ff;
   assign fend        = rend && ((RW'(out_row_ff) + RW'(1)) >= height_ext);

   always_comb begin
      flags.has_out   = produce;
      flags.commit_wr = !(produce && fend);
      flags.left_en   = out_col_ff != '0;
      flags.right_en  = !rend;
      flags.use_top   = (in_row_ff > RW'(1)) && ((in_row_ff - RW'(2)) < height_ext);
      flags.use_mid   = (in_row_ff != '0) && ((in_row_ff - RW'(1)) < height_ext);
      flags.use_bot   = in_image;
      flags.row_end   = rend;
      flags.frame_end = fend;
   end

   assign addr   = in_col_ff;
   assign kernel = kern_ff;

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      kern_in    = kern_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      restart    = 1'b0;
      if (csr_we) begin
         case (csr_index)
            c3zp_pkg::CSR_IMAGE_WIDTH: begin
               width_in = eff_width;
               restart  = 1'b1;
            end
            c3zp_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = (csr_wdata[c3zp_pkg::ROW_W-1:0] == '0) ?
                           c3zp_pkg::ROW_W'(1) : csr_wdata[c3zp_pkg::ROW_W-1:0];
               restart   = 1'b1;
            end
            c3zp_pkg::CSR_KERNEL_TOP:    kern_in[0] = csr_wdata[c3zp_pkg::KROW_W-1:0];
            c3zp_pkg::CSR_KERNEL_MIDDLE: kern_in[1] = csr_wdata[c3zp_pkg::KROW_W-1:0];
            c3zp_pkg::CSR_KERNEL_BOTTOM: kern_in[2] = csr_wdata[c3zp_pkg::KROW_W-1:0];
            default: ;
         endcase
      end else if (accept && !ignore) begin
         if (produce && fend) begin
            restart = 1'b1;
         end else begin
            if (produce) begin
               if (rend) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + c3zp_pkg::ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + AW'(1);
               end
            end
            if (in_col_last) begin
               in_col_in = '0;
               in_row_in = in_row_ff + RW'(1);
            end else begin
               in_col_in = in_col_ff + AW'(1);
            end
         end
      end
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RESET_W;
         height_ff  <= c3zp_pkg::IMAGE_HEIGHT_RESET;
         kern_ff[0] <= c3zp_pkg::KERNEL_TOP_RESET;
         kern_ff[1] <= c3zp_pkg::KERNEL_MIDDLE_RESET;
         kern_ff[2] <= c3zp_pkg::KERNEL_BOTTOM_RESET;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         kern_ff    <= kern_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      WW'(in_col_ff) < width_ff)
      else $error("input column beyond the image width");

   a_out_col_in_range: assert property (@(posedge clock) disable iff (reset)
      WW'(out_col_ff) < width_ff)
      else $error("output column beyond the image width");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      in_row_ff <= height_ext + RW'(1))
      else $error("input row ran past the drain rows");

endmodule

>>> design/c3zp_line_buf.sv
// ----------------------------------------------------------------------------
// c3zp_line_buf
// Two line buffers holding the two previous image rows. Read at the column
// of a new transfer, written back at the same column when that transfer
// leaves the window stage. A write and a read of the same column in one
// cycle are bypassed.
// ----------------------------------------------------------------------------
module c3zp_line_buf #(
   parameter int MAX_WIDTH = c3zp_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           rd_en,
   input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr,
   output logic signed [c3zp_pkg::PIX_W-1:0]              rd_top,
   output logic signed [c3zp_pkg::PIX_W-1:0]              rd_mid,
   input  logic                                           wr_en,
   input  logic signed [c3zp_pkg::PIX_W-1:0]              wr_top,
   input  logic signed [c3zp_pkg::PIX_W-1:0]              wr_mid
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic signed [c3zp_pkg::PIX_W-1:0] top_mem_ff [MAX_WIDTH];
   logic signed [c3zp_pkg::PIX_W-1:0] mid_mem_ff [MAX_WIDTH];
   logic signed [c3zp_pkg::PIX_W-1:0] rd_top_ff;
   logic signed [c3zp_pkg::PIX_W-1:0] rd_mid_ff;
   logic [AW-1:0]                     addr_ff;
   logic                              bypass;

   assign bypass = wr_en && (addr_ff == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         top_mem_ff[addr_ff] <= wr_top;
         mid_mem_ff[addr_ff] <= wr_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         addr_ff   <= rd_addr;
         rd_top_ff <= bypass ? wr_top : top_mem_ff[rd_addr];
         rd_mid_ff <= bypass ? wr_mid : mid_mem_ff[rd_addr];
      end
   end

   assign rd_top = rd_top_ff;
   assign rd_mid = rd_mid_ff;

endmodule

>>> design/c3zp_datapath.sv
// ----------------------------------------------------------------------------
// c3zp_datapath
// Window stage, product register and result register. The window stage
// forms the new column, shifts the 3x3 window and writes the line buffers;
// nine products are registered and then summed into the result register.
// ----------------------------------------------------------------------------
module c3zp_datapath (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           load,
   output logic                                           load_ready,
   input  c3zp_pkg::item_flags_type                       flags_in,
   input  logic signed [c3zp_pkg::PIX_W-1:0]              pixel_in,
   input  logic [c3zp_pkg::KERNEL_SIZE-1:0][c3zp_pkg::KROW_W-1:0] kernel,
   input  logic signed [c3zp_pkg::PIX_W-1:0]              rd_top,
   input  logic signed [c3zp_pkg::PIX_W-1:0]              rd_mid,
   output logic                                           wr_en,
   output logic signed [c3zp_pkg::PIX_W-1:0]              wr_top,
   output logic signed [c3zp_pkg::PIX_W-1:0]              wr_mid,
   output logic                                           rsp_valid,
   input  logic                                           rsp_ready,
   output logic signed [c3zp_pkg::SUM_W-1:0]              rsp_value,
   output logic                                           rsp_row_end,
   output logic                                           rsp_frame_end
);

   localparam int K = c3zp_pkg::KERNEL_SIZE;

   logic                              a_valid_ff;
   c3zp_pkg::item_flags_type          a_flags_ff;
   logic signed [c3zp_pkg::PIX_W-1:0] a_pix_ff;
   logic signed [c3zp_pkg::PIX_W-1:0] win_ff [K][2];

   logic                              p_valid_ff;
   logic                              p_rend_ff;
   logic                              p_fend_ff;
   logic signed [c3zp_pkg::SUM_W-1:0] prod_ff [K][K];
   logic signed [c3zp_pkg::SUM_W-1:0] prod_in [K][K];

   logic                              r_valid_ff;
   logic                              r_rend_ff;
   logic                              r_fend_ff;
   logic signed [c3zp_pkg::SUM_W-1:0] r_sum_ff;
   logic signed [c3zp_pkg::SUM_W-1:0] sum_in;

   logic signed [c3zp_pkg::PIX_W-1:0] col [K];
   logic signed [c3zp_pkg::PIX_W-1:0] opd [K][K];
   logic                              r_free;
   logic                              p_adv;
   logic                              p_free;
   logic                              a_go;

   assign r_free     = !r_valid_ff || rsp_ready;
   assign p_adv      = p_valid_ff && r_free;
   assign p_free     = !p_valid_ff || r_free;
   assign a_go       = a_valid_ff && (!a_flags_ff.has_out || p_free);
   assign load_ready = !a_valid_ff || a_go;

   assign col[0] = a_flags_ff.use_top ? rd_top : '0;
   assign col[1] = a_flags_ff.use_mid ? rd_mid : '0;
   assign col[2] = a_flags_ff.use_bot ? a_pix_ff : '0;

   assign wr_en  = a_go && a_flags_ff.commit_wr;
   assign wr_top = col[1];
   assign wr_mid = col[2];

   always_comb begin
      for (int k = 0; k < K; k++) begin
         opd[k][0] = a_flags_ff.left_en ? win_ff[k][0] : '0;
         opd[k][1] = win_ff[k][1];
         opd[k][2] = a_flags_ff.right_en ? col[k] : '0;
         for (int l = 0; l < K; l++) begin
            prod_in[k][l] = c3zp_pkg::SUM_W'(c3zp_pkg::coef(kernel[k], l)) *
                            c3zp_pkg::SUM_W'(opd[k][l]);
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < K; k++) begin
         for (int l = 0; l < K; l++) begin
            sum_in = sum_in + prod_ff[k][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (load) begin
         a_valid_ff <= 1'b1;
      end else if (a_go) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_flags_ff <= flags_in;
         a_pix_ff   <= pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < K; k++) begin
            win_ff[k][0] <= '0;
            win_ff[k][1] <= '0;
         end
      end else if (wr_en) begin
         for (int k = 0; k < K; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= col[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (a_go && a_flags_ff.has_out) begin
         p_valid_ff <= 1'b1;
      end else if (p_adv) begin
         p_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_go && a_flags_ff.has_out) begin
         prod_ff   <= prod_in;
         p_rend_ff <= a_flags_ff.row_end;
         p_fend_ff <= a_flags_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (p_adv) begin
         r_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         r_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (p_adv) begin
         r_sum_ff  <= sum_in;
         r_rend_ff <= p_rend_ff;
         r_fend_ff <= p_fend_ff;
      end
   end

   assign rsp_valid     = r_valid_ff;
   assign rsp_value     = r_sum_ff;
   assign rsp_row_end   = r_rend_ff;
   assign rsp_frame_end = r_fend_ff;

   a_stall_holds_window_stage: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !a_go |=> a_valid_ff && $stable(a_pix_ff) && $stable(a_flags_ff))
      else $error("window stage item changed while stalled");

   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff && r_fend_ff |-> r_rend_ff)
      else $error("frame end without row end");

   a_no_write_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !(a_flags_ff.has_out && a_flags_ff.frame_end))
      else $error("state written by the frame end item");

   a_result_kept_until_taken: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff && !rsp_ready |=> r_valid_ff && $stable(r_sum_ff))
      else $error("result register lost a pending result");

endmodule

>>> design/conv2d_3x3_zero_pad_top.sv
// ----------------------------------------------------------------------------
// conv2d_3x3_zero_pad_top
// Streaming 3x3 convolution with zero padding. Pixels enter in raster order
// and one transfer is taken per clock cycle unless the result path stalls;
// each result leaves through a line buffer read register, a product
// register and a result register. Results lag the input by one row
// plus one pixel, so after the last pixel of an image the source sends
// width+1 drain transfers (mode 1) to flush the remaining results; a drain
// transfer sent while pixels are still expected is dropped. Results are the
// wrapped 32-bit sums of the unflipped kernel over the neighborhood. Writing
// the width or height restarts the raster position. The line buffers need no
// clearing after reset: every entry used within an image was written earlier
// in that image.
// ----------------------------------------------------------------------------
module conv2d_3x3_zero_pad_top #(
   parameter int MAX_WIDTH = c3zp_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic signed [c3zp_pkg::PIX_W-1:0]   req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [c3zp_pkg::SUM_W-1:0]   rsp_value,
   output logic                                rsp_row_end,
   output logic                                rsp_frame_end,
   input  logic                                csr_we,
   input  logic [c3zp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [c3zp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   c3zp_pkg::item_flags_type          flags;
   logic                              ignore;
   logic                              accept;
   logic                              load;
   logic [AW-1:0]                     addr;
   logic [c3zp_pkg::KERNEL_SIZE-1:0][c3zp_pkg::KROW_W-1:0] kernel;
   logic signed [c3zp_pkg::PIX_W-1:0] rd_top;
   logic signed [c3zp_pkg::PIX_W-1:0] rd_mid;
   logic                              wr_en;
   logic signed [c3zp_pkg::PIX_W-1:0] wr_top;
   logic signed [c3zp_pkg::PIX_W-1:0] wr_mid;

   assign accept = req_valid && req_ready;
   assign load   = accept && !ignore;

   c3zp_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .mode      (req_mode),
      .flags     (flags),
      .ignore    (ignore),
      .addr      (addr),
      .kernel    (kernel)
   );

   c3zp_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (load),
      .rd_addr (addr),
      .rd_top  (rd_top),
      .rd_mid  (rd_mid),
      .wr_en   (wr_en),
      .wr_top  (wr_top),
      .wr_mid  (wr_mid)
   );

   c3zp_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .load_ready    (req_ready),
      .flags_in      (flags),
      .pixel_in      (req_pixel),
      .kernel        (kernel),
      .rd_top        (rd_top),
      .rd_mid        (rd_mid),
      .wr_en         (wr_en),
      .wr_top        (wr_top),
      .wr_mid        (wr_mid),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the streaming 3x3 zero-padded convolution. A
// small checker class tracks the raster position, both line buffers and the
// 3x3 window. It predicts each convolved pixel, with its row and frame flags,
// from the accepted transfers and compares the results in order. The stimulus
// starts with hand-picked frames at extreme pixels, kernels and sizes. Then a
// cut-off maximum-width frame follows, and after it small random frames with
// early drain ticks, surplus pixels, cut-off frames and random stalls on both
// channels.
// ----------------------------------------------------------------------------

typedef enum bit {
   MODE_PIXEL = 1'b0,
   MODE_DRAIN = 1'b1
} item_mode_type;

typedef struct {
   logic [31:0] value;
   bit          row_end;
   bit          frame_end;
} conv_output_type;

class conv_window_checker;
   logic [10:0]        width_reg;
   logic [15:0]        height_reg;
   logic [47:0]        kernel_row [3];
   logic signed [15:0] line_mem [2*c3zp_pkg::MAX_WIDTH_DEFAULT];
   logic signed [15:0] win [9];
   int unsigned        in_col;
   int unsigned        in_row;
   int unsigned        out_col;
   int unsigned        out_row;
   conv_output_type    expected_outputs [$];
   int                 mismatches;
   int                 checked;

   function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function void reset_state();
      width_reg = 11'd1024;
      height_reg = 16'd1024;
      kernel_row[0] = 48'd0;
      kernel_row[1] = 48'd4096;
      kernel_row[2] = 48'd0;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      restart();
      expected_outputs.delete();
      mismatches = 0;
      checked = 0;
   endfunction

   function int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > c3zp_pkg::MAX_WIDTH_DEFAULT) return c3zp_pkg::MAX_WIDTH_DEFAULT;
      return width_reg;
   endfunction

   function int unsigned active_height();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function int kernel_tap(int k, int l);
      logic [15:0] raw;
      raw = 16'(kernel_row[k] >> (16 * l));
      return int'($signed(raw));
   endfunction

   function void write_register(logic [c3zp_pkg::CSR_IDX_W-1:0] index,
                                logic [c3zp_pkg::CSR_DATA_W-1:0] data);
      case (index)
         c3zp_pkg::CSR_IMAGE_WIDTH: begin
            width_reg = data[10:0];
            restart();
         end
         c3zp_pkg::CSR_IMAGE_HEIGHT: begin
            height_reg = data[15:0];
            restart();
         end
         c3zp_pkg::CSR_KERNEL_TOP:    kernel_row[0] = data[47:0];
         c3zp_pkg::CSR_KERNEL_MIDDLE: kernel_row[1] = data[47:0];
         c3zp_pkg::CSR_KERNEL_BOTTOM: kernel_row[2] = data[47:0];
         default: ;
      endcase
   endfunction

   // Returns 0 when the transfer is dropped without any effect.
   function bit accept_pixel(item_mode_type mode, logic signed [15:0] pixel);
      int unsigned        w;
      int unsigned        h;
      int unsigned        r;
      int unsigned        c;
      int unsigned        ocol;
      logic signed [15:0] col [3];
      int                 sum;
      int                 left;
      int                 mid;
      int                 right;
      int                 k;
      conv_output_type    res;
      w = active_width();
      h = active_height();
      r = in_row;
      c = in_col;
      if (c >= w) c = 0;
      if (mode == MODE_DRAIN && r < h) return 1'b0;
      col[0] = (r >= 2 && r - 2 < h) ? line_mem[c] : 16'sd0;
      col[1] = (r >= 1 && r - 1 < h) ? line_mem[c3zp_pkg::MAX_WIDTH_DEFAULT + c] : 16'sd0;
      col[2] = (r < h) ? pixel : 16'sd0;
      if (r >= 2 || (r == 1 && c >= 1)) begin
         ocol = out_col;
         sum = 0;
         for (k = 0; k < 3; k++) begin
            left = (ocol >= 1) ? int'(win[k*3+1]) : 0;
            mid = int'(win[k*3+2]);
            right = (ocol + 1 < w) ? int'(col[k]) : 0;
            sum = sum + kernel_tap(k, 0) * left;
            sum = sum + kernel_tap(k, 1) * mid;
            sum = sum + kernel_tap(k, 2) * right;
         end
         res.value = sum;
         res.row_end = (ocol + 1 >= w);
         res.frame_end = res.row_end && (out_row + 1 >= h);
         expected_outputs.push_back(res);
         if (res.frame_end) begin
            restart();
            return 1'b1;
         end
         if (res.row_end) begin
            out_col = 0;
            out_row++;
         end else begin
            out_col = ocol + 1;
         end
      end
      for (k = 0; k < 3; k++) begin
         win[k*3] = win[k*3+1];
         win[k*3+1] = win[k*3+2];
         win[k*3+2] = col[k];
      end
      line_mem[c] = col[1];
      line_mem[c3zp_pkg::MAX_WIDTH_DEFAULT + c] = col[2];
      if (c + 1 >= w) begin
         in_col = 0;
         in_row = r + 1;
      end else begin
         in_col = c + 1;
      end
      return 1'b1;
   endfunction

   function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endfunction

   function void check_output(logic [31:0] value, bit row_end, bit frame_end);
      conv_output_type want;
      if (expected_outputs.size() == 0) begin
         mismatches++;
         $display("%0t ns: unexpected result, expected none, actual %h %b %b",
                  $time, value, row_end, frame_end);
         return;
      end
      want = expected_outputs.pop_front();
      checked++;
      if (value !== want.value) report("value", want.value, value);
      if (row_end !== want.row_end) report("row_end", 32'(want.row_end), 32'(row_end));
      if (frame_end !== want.frame_end) report("frame_end", 32'(want.frame_end), 32'(frame_end));
   endfunction

   function int pending();
      return expected_outputs.size();
   endfunction
endclass

module tb;

   localparam int CLOCK_PERIOD   = 12;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int LONG_HOLD      = 500;
   localparam int HOLD_AFTER     = c3zp_pkg::MAX_WIDTH_DEFAULT + 2;
   localparam int TOTAL_ITEMS    = 1150;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_mode = 1'b0;
   logic signed [c3zp_pkg::PIX_W-1:0] req_pixel = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [c3zp_pkg::SUM_W-1:0] rsp_value;
   logic                              rsp_row_end;
   logic                              rsp_frame_end;
   logic                              csr_we = 1'b0;
   logic [c3zp_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [c3zp_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   conv_window_checker sb = new();

   int  items_used = 0;
   int  dropped_items = 0;
   int  frames_sent = 0;
   int  settings_used = 0;
   int  burst_left = 0;
   bit  steady_sender = 1'b0;
   bit  long_hold_done = 1'b0;

   conv2d_3x3_zero_pad_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_value(rsp_value),
      .rsp_row_end(rsp_row_end),
      .rsp_frame_end(rsp_frame_end),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_output(rsp_value, rsp_row_end, rsp_frame_end);
   end

   initial begin
      int style;
      int stretch;
      int hold_count;
      forever begin
         style = $urandom_range(0, 3);
         stretch = $urandom_range(8, 80);
         repeat (stretch) begin
            @(negedge clock);
            if (!long_hold_done && items_used > HOLD_AFTER) begin
               long_hold_done = 1'b1;
               for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) begin
                  rsp_ready <= 1'b0;
                  @(negedge clock);
               end
            end
            case (style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= ($urandom_range(0, 5) != 0);
            endcase
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("conv2d_3x3_zero_pad_top regression: fail");
      $finish;
   end

   function automatic logic signed [15:0] rand_pixel();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sd0;
         3:       return 16'(int'($urandom_range(0, 15)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] rand_kernel_row();
      case ($urandom_range(0, 5))
         0:       return {3{16'h8000}};
         1:       return {3{16'h7FFF}};
         2:       return {3{16'hFFFF}};
         3:       return {16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                          16'($urandom_range(0, 7))};
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   function automatic int unsigned clamp_width(int unsigned w);
      if (w == 0) return 1;
      if (w > c3zp_pkg::MAX_WIDTH_DEFAULT) return c3zp_pkg::MAX_WIDTH_DEFAULT;
      return w;
   endfunction

   task automatic csr_write(input logic [c3zp_pkg::CSR_IDX_W-1:0] index,
                            input logic [47:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(index, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_item(input item_mode_type mode, input logic signed [15:0] pixel);
      int gap;
      if (burst_left == 0) begin
         gap = steady_sender ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_pixel <= pixel;
      do @(posedge clock); while (!req_ready);
      if (sb.accept_pixel(mode, pixel)) items_used++;
      else dropped_items++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A cut-off frame sends only the first pixel_count pixels and no closing drain ticks.
   task automatic push_frame(input int unsigned w, input int unsigned h,
                             input int pixel_count);
      int total;
      int i;
      total = (pixel_count < 0) ? w * h : pixel_count;
      for (i = 0; i < total; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(MODE_DRAIN, 16'($urandom));
         send_item(MODE_PIXEL, rand_pixel());
      end
      if (pixel_count >= 0) return;
      for (i = 0; i < w + 1; i++) begin
         if ($urandom_range(0, 7) == 0) send_item(MODE_PIXEL, rand_pixel());
         else send_item(MODE_DRAIN, 16'($urandom));
      end
      if ($urandom_range(0, 9) == 0) send_item(MODE_DRAIN, 16'($urandom));
      frames_sent++;
   endtask

   task automatic run_random_setting();
      int unsigned w_reg;
      int unsigned h_reg;
      int unsigned w;
      int unsigned h;
      int          frames;
      int          f;
      case ($urandom_range(0, 19))
         0:       w_reg = 0;
         1:       w_reg = 1;
         14, 15, 16, 17: w_reg = $urandom_range(9, 40);
         default: w_reg = $urandom_range(2, 8);
      endcase
      case ($urandom_range(0, 19))
         0:       h_reg = 0;
         1:       h_reg = 16'hFFFF;
         default: h_reg = $urandom_range(1, 6);
      endcase
      csr_write(c3zp_pkg::CSR_IMAGE_WIDTH, 48'(w_reg));
      csr_write(c3zp_pkg::CSR_IMAGE_HEIGHT, 48'(h_reg));
      if ($urandom_range(0, 2) == 0) csr_write(c3zp_pkg::CSR_KERNEL_TOP, rand_kernel_row());
      if ($urandom_range(0, 2) == 0) csr_write(c3zp_pkg::CSR_KERNEL_MIDDLE, rand_kernel_row());
      if ($urandom_range(0, 2) == 0) csr_write(c3zp_pkg::CSR_KERNEL_BOTTOM, rand_kernel_row());
      settings_used++;
      steady_sender = ($urandom_range(0, 3) == 0);
      w = clamp_width(w_reg);
      h = (h_reg == 0) ? 1 : h_reg;
      if (h_reg == 16'hFFFF) begin
         push_frame(w, h, $urandom_range(1, w * 6));
      end else begin
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames; f++) begin
            if (f == frames - 1 && $urandom_range(0, 4) == 0)
               push_frame(w, h, $urandom_range(1, w * h));
            else
               push_frame(w, h, -1);
         end
      end
      wait_idle();
   endtask

   initial begin
      sb.reset_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extreme pixels and kernels, an early drain tick and a surplus pixel.
      csr_write(c3zp_pkg::CSR_IMAGE_WIDTH, 48'd3);
      csr_write(c3zp_pkg::CSR_IMAGE_HEIGHT, 48'd2);
      csr_write(c3zp_pkg::CSR_KERNEL_TOP, {16'h7FFF, 16'h8000, 16'h7FFF});
      csr_write(c3zp_pkg::CSR_KERNEL_MIDDLE, {3{16'h8000}});
      csr_write(c3zp_pkg::CSR_KERNEL_BOTTOM, {16'h7FFF, 16'h0001, 16'hFFFF});
      steady_sender = 1'b1;
      send_item(MODE_DRAIN, 16'sh5A5A);
      send_item(MODE_PIXEL, 16'sh7FFF);
      send_item(MODE_PIXEL, 16'sh8000);
      send_item(MODE_PIXEL, 16'sh7FFF);
      send_item(MODE_PIXEL, 16'sh8000);
      send_item(MODE_PIXEL, 16'sh0000);
      send_item(MODE_PIXEL, 16'shFFFF);
      send_item(MODE_DRAIN, 16'sh0000);
      send_item(MODE_PIXEL, 16'sh1234);
      send_item(MODE_DRAIN, 16'shFFFF);
      send_item(MODE_DRAIN, 16'sh0000);
      wait_idle();

      // Zero width and height fall back to a single pixel.
      csr_write(c3zp_pkg::CSR_IMAGE_WIDTH, 48'd0);
      csr_write(c3zp_pkg::CSR_IMAGE_HEIGHT, 48'd0);
      csr_write(c3zp_pkg::CSR_KERNEL_MIDDLE, {3{16'h8000}});
      send_item(MODE_PIXEL, 16'sh8000);
      send_item(MODE_DRAIN, 16'sh0000);
      send_item(MODE_DRAIN, 16'sh0000);
      send_item(MODE_DRAIN, 16'sh7FFF);
      wait_idle();

      csr_write(c3zp_pkg::CSR_IMAGE_WIDTH, 48'd1);
      csr_write(c3zp_pkg::CSR_IMAGE_HEIGHT, 48'd3);
      csr_write(c3zp_pkg::CSR_KERNEL_TOP, {3{16'h0001}});
      csr_write(c3zp_pkg::CSR_KERNEL_BOTTOM, {3{16'hFFFF}});
      send_item(MODE_PIXEL, 16'sh7FFF);
      send_item(MODE_PIXEL, 16'sh8000);
      send_item(MODE_PIXEL, 16'sh0001);
      send_item(MODE_DRAIN, 16'sh0000);
      send_item(MODE_DRAIN, 16'sh0000);
      wait_idle();
      settings_used += 3;

      // A width above the line buffer size is clamped to the largest row. The
      // frame is cut off a little after its first results, and the long
      // receiver stall lands on that stretch.
      csr_write(c3zp_pkg::CSR_IMAGE_WIDTH, 48'd2047);
      csr_write(c3zp_pkg::CSR_IMAGE_HEIGHT, 48'd1);
      csr_write(c3zp_pkg::CSR_KERNEL_TOP, rand_kernel_row());
      csr_write(c3zp_pkg::CSR_KERNEL_MIDDLE, rand_kernel_row());
      csr_write(c3zp_pkg::CSR_KERNEL_BOTTOM, rand_kernel_row());
      steady_sender = 1'b0;
      push_frame(c3zp_pkg::MAX_WIDTH_DEFAULT, 1, c3zp_pkg::MAX_WIDTH_DEFAULT + 24);
      wait_idle();
      settings_used++;

      while (items_used < TOTAL_ITEMS) run_random_setting();

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d frames over %0d size and kernel settings.",
               frames_sent, settings_used);
      $display("Used %0d transfers, dropped %0d, checked %0d results, %0d mismatches.",
               items_used, dropped_items, sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("conv2d_3x3_zero_pad_top regression: pass");
      end else begin
         $display("conv2d_3x3_zero_pad_top regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
design/c3zp_pkg.sv
design/c3zp_ctrl.sv
design/c3zp_line_buf.sv
design/c3zp_datapath.sv
design/conv2d_3x3_zero_pad_top.sv
tb/tb.sv
